// ===== rtl/core/atb_pkg.sv =====
// ----------------------------------------------------------------------------
// atb_pkg: shared types and constants for the arc to Bezier converter
// Item layouts, the queued job descriptor, the back-end sequencer states,
// the fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package atb_pkg;

    // One arc as it arrives on the input channel.
    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic        [23:0] radius;
        logic        [15:0] start_angle;
        logic        [15:0] stop_angle;
    } atb_in_t;

    // One Bezier segment as it leaves on the output channel.
    typedef struct packed {
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
        logic signed [31:0] ctrl_a_x;
        logic signed [31:0] ctrl_a_y;
        logic signed [31:0] ctrl_b_x;
        logic signed [31:0] ctrl_b_y;
        logic        [2:0]  segment_total;
        logic               last;
    } atb_out_t;

    // Classified arc handed from the front end to the back end.
    // Angles are in 32-bit turn units.
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic        [23:0] r;
        logic        [31:0] t0;
        logic        [29:0] rem;
        logic        [2:0]  total;
    } atb_job_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEG,
        BK_TRIG,
        BK_DIV1,
        BK_DIV2,
        BK_MUL,
        BK_SUM,
        BK_EMIT
    } atb_state_t;

    // CORDIC start value (gain compensated, Q2.30) and iteration count.
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam int                 CORDIC_STEPS = 30;

    // Control point factor for a quarter turn, Q2.30.
    localparam logic [31:0] K_QUARTER    = 32'd593011235;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Reciprocal of three scaled by 2^33; exact floor division for 32-bit values.
    localparam logic [31:0] RECIP_THREE  = 32'hAAAA_AAAB;

    // Arctangent of 2^-i in 32-bit turn units.
    function automatic logic [31:0] atb_atan(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'd536870912;
                5'd1:    v = 32'd316933406;
                5'd2:    v = 32'd167458907;
                5'd3:    v = 32'd85004756;
                5'd4:    v = 32'd42667331;
                5'd5:    v = 32'd21354465;
                5'd6:    v = 32'd10679838;
                5'd7:    v = 32'd5340245;
                5'd8:    v = 32'd2670163;
                5'd9:    v = 32'd1335087;
                5'd10:   v = 32'd667544;
                5'd11:   v = 32'd333772;
                5'd12:   v = 32'd166886;
                5'd13:   v = 32'd83443;
                5'd14:   v = 32'd41722;
                5'd15:   v = 32'd20861;
                5'd16:   v = 32'd10430;
                5'd17:   v = 32'd5215;
                5'd18:   v = 32'd2608;
                5'd19:   v = 32'd1304;
                5'd20:   v = 32'd652;
                5'd21:   v = 32'd326;
                5'd22:   v = 32'd163;
                5'd23:   v = 32'd81;
                5'd24:   v = 32'd41;
                5'd25:   v = 32'd20;
                5'd26:   v = 32'd10;
                5'd27:   v = 32'd5;
                5'd28:   v = 32'd3;
                5'd29:   v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/core/atb_cordic.sv =====
// ----------------------------------------------------------------------------
// atb_cordic: iterative sine and cosine
// Reduces the angle to the nearest quadrant, then runs one CORDIC rotation
// step per cycle and maps the result back. Q2.30 outputs.
// ----------------------------------------------------------------------------
module atb_cordic
    import atb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         step_reg;
    logic [1:0]         quad_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;

    logic [31:0]        shifted;
    logic [1:0]         quad;
    logic [31:0]        resid;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] atan_step;
    logic signed [33:0] neg_x;
    logic signed [33:0] neg_y;

    // Quadrant reduction of the incoming angle.
    always_comb
    begin
        shifted = angle + 32'h2000_0000;
        quad    = shifted[31:30];
        resid   = angle - {quad, 30'b0};
    end

    // Shifted terms of the current rotation step.
    always_comb
    begin
        dx        = y_reg >>> step_reg;
        dy        = x_reg >>> step_reg;
        atan_step = $signed({2'b00, atb_atan(step_reg)});
    end

    // Control: one step per cycle while busy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 5'(CORDIC_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Rotation datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quad_reg <= quad;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= 34'(signed'(resid));
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_step;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_step;
            end
        end
    end

    // Map the first-quadrant result back to the original quadrant.
    always_comb
    begin
        neg_x = -x_reg;
        neg_y = -y_reg;
        case (quad_reg)
            2'd0:
            begin
                cos_val = x_reg[31:0];
                sin_val = y_reg[31:0];
            end
            2'd1:
            begin
                cos_val = neg_y[31:0];
                sin_val = x_reg[31:0];
            end
            2'd2:
            begin
                cos_val = neg_x[31:0];
                sin_val = neg_y[31:0];
            end
            default:
            begin
                cos_val = y_reg[31:0];
                sin_val = neg_x[31:0];
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/atb_div.sv =====
// ----------------------------------------------------------------------------
// atb_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. The upper dividend word must be below the divisor.
// ----------------------------------------------------------------------------
module atb_div
    import atb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // Trial subtraction for the next quotient bit.
    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: the low word shifts out dividend bits and in quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            quo_reg <= dividend[31:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/atb_front.sv =====
// ----------------------------------------------------------------------------
// atb_front: arc intake and classification
// Masks the radius and angles, splits the span into quarter turns plus a
// remainder, and queues the classified arc in a two-entry queue.
// ----------------------------------------------------------------------------
module atb_front
    import atb_pkg::*;
#(
    parameter int ANGLE_BITS  = 16,
    parameter int RADIUS_BITS = 24
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  atb_in_t  in_item,
    output logic     job_valid,
    input  logic     job_pop,
    output atb_job_t job
);

    localparam int SHIFT = 32 - ANGLE_BITS;

    atb_job_t    entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    logic [31:0] amask;
    logic [23:0] rmask;
    logic [31:0] a0w;
    logic [31:0] a1w;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] diff;
    logic [2:0]  nq;
    logic        push;
    logic        pop;
    atb_job_t    cls;

    // Masks that keep the low ANGLE_BITS and RADIUS_BITS bits.
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            amask[i] = (i < ANGLE_BITS);
        end
        for (int i = 0; i < 24; i++)
        begin
            rmask[i] = (i < RADIUS_BITS);
        end
    end

    // Classify: span in 32-bit turn units, whole quarters and remainder.
    always_comb
    begin
        a0w        = {16'b0, in_item.start_angle} & amask;
        a1w        = {16'b0, in_item.stop_angle} & amask;
        t0         = a0w << SHIFT;
        t1         = a1w << SHIFT;
        diff       = t1 - t0;
        nq         = (diff == 32'd0) ? 3'd4 : {1'b0, diff[31:30]};
        cls.cx     = in_item.centre_x;
        cls.cy     = in_item.centre_y;
        cls.r      = in_item.radius & rmask;
        cls.t0     = t0;
        cls.rem    = diff[29:0];
        cls.total  = nq + {2'b0, (diff[29:0] != 30'd0)};
    end

    // Two-entry queue between the front and back ends.
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (count_reg != 2'd0);
    assign pop       = job_pop && job_valid;
    assign job       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/atb_back.sv =====
// ----------------------------------------------------------------------------
// atb_back: segment generation
// Sequences one shared CORDIC, one divider and one multiplier over each
// segment of a queued arc, then sums, truncates and saturates the points
// into the output register.
// ----------------------------------------------------------------------------
module atb_back
    import atb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_pop,
    input  atb_job_t job,
    output logic     out_valid,
    input  logic     out_ready,
    output atb_out_t out_item
);

    atb_state_t state_reg;
    atb_state_t state_next;

    // Arc and segment registers.
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic        [23:0] r_reg;
    logic        [2:0]  total_reg;
    logic        [2:0]  left_reg;
    logic        [31:0] a1_reg;
    logic        [31:0] a2_reg;
    logic        [31:0] qs_reg;
    logic               short_reg;
    logic        [1:0]  trig_reg;

    // Trig values, factor and products.
    logic signed [31:0] c1_reg;
    logic signed [31:0] s1_reg;
    logic signed [31:0] c2_reg;
    logic signed [31:0] s2_reg;
    logic        [31:0] k_reg;
    logic        [3:0]  midx_reg;
    logic               mph_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] mtmp_reg;
    logic signed [63:0] coord_reg [4];
    logic signed [65:0] m_reg [4];
    logic signed [65:0] end_reg [4];
    logic signed [65:0] ctl_reg [4];

    logic               out_valid_reg;
    atb_out_t           out_item_reg;

    // Unit handshakes.
    logic               cor_start;
    logic [31:0]        cor_angle;
    logic               cor_done;
    logic signed [31:0] cor_cos;
    logic signed [31:0] cor_sin;
    logic               div_start;
    logic [63:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [31:0]        div_quo;

    logic               out_load;
    logic               out_free;
    logic [1:0]         pair;
    logic [1:0]         csel;
    logic signed [63:0] psrc;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;
    logic signed [65:0] bx;
    logic signed [65:0] by;
    logic signed [65:0] xe [4];
    logic [63:0]        third_prod;
    logic [31:0]        k_scaled;
    atb_out_t           emit_item;

    function automatic logic signed [65:0] trunc30(input logic signed [65:0] v);
        logic signed [65:0] bias;
        begin
            bias = v[65] ? 66'sd1073741823 : 66'sd0;
            return (v + bias) >>> 30;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        begin
            if (v > 66'sd2147483647)
            begin
                res = 32'sh7FFF_FFFF;
            end
            else if (v < -66'sd2147483648)
            begin
                res = 32'sh8000_0000;
            end
            else
            begin
                res = v[31:0];
            end
            return res;
        end
    endfunction

    atb_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_val (cor_cos),
        .sin_val (cor_sin)
    );

    atb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = BK_SEG;
                end
            end
            BK_SEG:
            begin
                state_next = BK_TRIG;
            end
            BK_TRIG:
            begin
                if (cor_done)
                begin
                    if (trig_reg == 2'd1 && !short_reg)
                    begin
                        state_next = BK_MUL;
                    end
                    else if (trig_reg == 2'd2)
                    begin
                        state_next = cor_sin[31] ? BK_MUL : BK_DIV1;
                    end
                end
            end
            BK_DIV1:
            begin
                if (div_done)
                begin
                    state_next = BK_DIV2;
                end
            end
            BK_DIV2:
            begin
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                if (midx_reg == 4'd11 && mph_reg)
                begin
                    state_next = BK_SUM;
                end
            end
            BK_SUM:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (left_reg == 3'd1) ? BK_IDLE : BK_SEG;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Unit starts, queue pop and output load.
    always_comb
    begin
        job_pop      = 1'b0;
        cor_start    = 1'b0;
        cor_angle    = a1_reg;
        div_start    = 1'b0;
        div_dividend = {2'b0, cor_sin, 30'b0};
        div_divisor  = (cor_cos[31] || cor_cos == 32'sd0) ? 32'd1 : cor_cos;
        out_load     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                job_pop = job_valid;
            end
            BK_SEG:
            begin
                cor_start = 1'b1;
            end
            BK_TRIG:
            begin
                if (cor_done)
                begin
                    if (trig_reg == 2'd0)
                    begin
                        cor_start = 1'b1;
                        cor_angle = a2_reg;
                    end
                    else if (trig_reg == 2'd1 && short_reg)
                    begin
                        cor_start = 1'b1;
                        cor_angle = qs_reg;
                    end
                    else if (trig_reg == 2'd2 && !cor_sin[31])
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            BK_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    // Four thirds of the tangent: t + floor(t / 3), the third taken by
    // reciprocal multiplication.
    always_comb
    begin
        third_prod = {32'b0, k_reg} * {32'b0, RECIP_THREE};
        k_scaled   = k_reg + {1'b0, third_prod[63:33]};
    end

    // Multiplier operand selection: four radius products, then for each
    // offset the high and low halves against the factor.
    always_comb
    begin
        pair  = 2'((midx_reg - 4'd4) >> 1);
        csel  = pair ^ 2'b01;
        psrc  = coord_reg[csel];
        mul_a = $signed({9'b0, r_reg});
        mul_b = {c1_reg[31], c1_reg};
        if (midx_reg < 4'd4)
        begin
            case (midx_reg[1:0])
                2'd0:    mul_b = {c1_reg[31], c1_reg};
                2'd1:    mul_b = {s1_reg[31], s1_reg};
                2'd2:    mul_b = {c2_reg[31], c2_reg};
                default: mul_b = {s2_reg[31], s2_reg};
            endcase
        end
        else
        begin
            mul_a = $signed({1'b0, k_reg});
            if (!midx_reg[0])
            begin
                mul_b = psrc[62:30];
            end
            else
            begin
                mul_b = $signed({3'b0, psrc[29:0]});
            end
        end
        prod_next = mul_a * mul_b;
    end

    // Point sums.
    always_comb
    begin
        bx = $signed({{4{cx_reg[31]}}, cx_reg, 30'b0});
        by = $signed({{4{cy_reg[31]}}, cy_reg, 30'b0});
        for (int i = 0; i < 4; i++)
        begin
            xe[i] = 66'(coord_reg[i]);
        end
    end

    // Final truncation and saturation of the current segment.
    always_comb
    begin
        emit_item.seg_start_x   = sat32(end_reg[0]);
        emit_item.seg_start_y   = sat32(end_reg[1]);
        emit_item.seg_end_x     = sat32(end_reg[2]);
        emit_item.seg_end_y     = sat32(end_reg[3]);
        emit_item.ctrl_a_x      = sat32(trunc30(ctl_reg[0]));
        emit_item.ctrl_a_y      = sat32(trunc30(ctl_reg[1]));
        emit_item.ctrl_b_x      = sat32(trunc30(ctl_reg[2]));
        emit_item.ctrl_b_y      = sat32(trunc30(ctl_reg[3]));
        emit_item.segment_total = total_reg;
        emit_item.last          = (left_reg == 3'd1);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            midx_reg      <= '0;
            mph_reg       <= 1'b0;
            trig_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == BK_MUL)
            begin
                mph_reg <= ~mph_reg;
                if (mph_reg)
                begin
                    midx_reg <= midx_reg + 4'd1;
                end
            end
            else
            begin
                mph_reg  <= 1'b0;
                midx_reg <= '0;
            end
            if (state_reg == BK_SEG)
            begin
                trig_reg <= '0;
            end
            else if (state_reg == BK_TRIG && cor_done)
            begin
                trig_reg <= trig_reg + 2'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        // Load a new arc and set up its first segment.
        if (state_reg == BK_IDLE && job_valid)
        begin
            cx_reg    <= job.cx;
            cy_reg    <= job.cy;
            r_reg     <= job.r;
            total_reg <= job.total;
            left_reg  <= job.total;
            a1_reg    <= job.t0;
            qs_reg    <= {4'b0, job.rem[29:2]};
            if (job.rem != 30'd0)
            begin
                a2_reg    <= job.t0 + {2'b0, job.rem};
                short_reg <= 1'b1;
            end
            else
            begin
                a2_reg    <= job.t0 + QUARTER_TURN;
                short_reg <= 1'b0;
            end
        end

        // Capture trig results and fix the factor.
        if (state_reg == BK_TRIG && cor_done)
        begin
            case (trig_reg)
                2'd0:
                begin
                    c1_reg <= cor_cos;
                    s1_reg <= cor_sin;
                end
                2'd1:
                begin
                    c2_reg <= cor_cos;
                    s2_reg <= cor_sin;
                    if (!short_reg)
                    begin
                        k_reg <= K_QUARTER;
                    end
                end
                default:
                begin
                    // A negative quarter-span sine gives a zero factor.
                    k_reg <= '0;
                end
            endcase
        end
        // The tangent lands first, then is scaled by four thirds.
        if (state_reg == BK_DIV1 && div_done)
        begin
            k_reg <= div_quo;
        end
        if (state_reg == BK_DIV2)
        begin
            k_reg <= k_scaled;
        end

        // Multiply, then accumulate on the following cycle.
        if (state_reg == BK_MUL)
        begin
            if (!mph_reg)
            begin
                prod_reg <= prod_next;
            end
            else if (midx_reg < 4'd4)
            begin
                coord_reg[midx_reg[1:0]] <= prod_reg[63:0];
            end
            else if (!midx_reg[0])
            begin
                mtmp_reg <= prod_reg;
            end
            else
            begin
                m_reg[pair] <= mtmp_reg + (prod_reg >>> 30);
            end
        end

        // Endpoint offsets and full control point sums.
        if (state_reg == BK_SUM)
        begin
            end_reg[0] <= 66'(cx_reg) + trunc30(xe[0]);
            end_reg[1] <= 66'(cy_reg) + trunc30(xe[1]);
            end_reg[2] <= 66'(cx_reg) + trunc30(xe[2]);
            end_reg[3] <= 66'(cy_reg) + trunc30(xe[3]);
            ctl_reg[0] <= bx + xe[0] - m_reg[0];
            ctl_reg[1] <= by + xe[1] + m_reg[1];
            if (short_reg)
            begin
                ctl_reg[2] <= bx + xe[2] + m_reg[2];
                ctl_reg[3] <= by + xe[3] - m_reg[3];
            end
            else
            begin
                ctl_reg[2] <= bx + m_reg[1] + xe[2];
                ctl_reg[3] <= by + m_reg[0] + xe[3];
            end
        end

        // Hand over the segment and step to the next quarter turn.
        if (out_load)
        begin
            out_item_reg <= emit_item;
            left_reg     <= left_reg - 3'd1;
            a1_reg       <= a2_reg;
            a2_reg       <= a2_reg + QUARTER_TURN;
            short_reg    <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/core/arc_to_bezier_segments_top.sv =====
// ----------------------------------------------------------------------------
// arc_to_bezier_segments_top: circular arc to cubic Bezier segments
// Converts one arc into one to four cubic Bezier segments.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_item) takes one arc per item:
//   centre, radius, start and stop angle. The output channel (out_valid,
//   out_ready, out_item) gives its segments in order of increasing angle,
//   with segment_total on each and last set on the final one.
//   Every segment runs through one shared 30-step CORDIC, one run per sine
//   and cosine pair, and one 33x33 multiplier. A leading partial segment
//   adds a third CORDIC run, one division and a reciprocal multiply for
//   its tangent factor.
//   A two-entry queue holds arcs ahead of the segment engine, so new arcs
//   are taken while a segment waits in the output register. When the
//   receiver stalls, the engine finishes the next segment and then holds.
//   Reset empties the queue and the output register; no clearing pass.
// ----------------------------------------------------------------------------
module arc_to_bezier_segments_top
    import atb_pkg::*;
#(
    parameter int ANGLE_BITS  = 16,
    parameter int RADIUS_BITS = 24
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  atb_in_t  in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output atb_out_t out_item
);

    logic     job_valid;
    logic     job_pop;
    atb_job_t job;

    atb_front #(
        .ANGLE_BITS  (ANGLE_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    atb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== bench/arc_to_bezier_segments_top_test.sv =====
// ----------------------------------------------------------------------------
// arc_to_bezier_segments_top_test: self-checking bench for the arc converter
// Feeds directed and random arcs through the valid/ready input channel. A
// scoreboard works out the expected Bezier segments of every accepted arc
// with its own fixed-point CORDIC model and checks each segment that leaves
// the output channel, in order. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arc_to_bezier_segments_top_test;
    import atb_pkg::*;

    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     RANDOM_ARCS = 420;
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint TRIG_GAIN   = 64'sd652032874;
    localparam longint K_QTR       = 64'sd593011235;
    localparam longint ARCTAN_TURN [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    // Expected segments and the fixed-point model that produces them.
    class segment_scoreboard;
        atb_out_t segments_due[$];
        int       mismatches;
        int       segments_seen;
        int       arcs_noted;

        function longint trunc_q30(longint p);
            return (p < 0) ? -((-p) >>> 30) : (p >>> 30);
        endfunction

        function logic [31:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[31:0];
        endfunction

        // Product of a Q2.30 factor and an offset in 2^-30 units, floored.
        function longint scale_k(longint k, longint p);
            longint h;
            longint l;
            h = p >>> 30;
            l = p - h * Q30_ONE;
            return k * h + ((k * l) >>> 30);
        endfunction

        // Quadrant reduction followed by a 30-step rotation.
        function void sin_cos(input logic [31:0] a, output longint c, output longint s);
            logic [31:0] q;
            logic [31:0] r;
            longint      x;
            longint      y;
            longint      z;
            longint      dx;
            longint      dy;
            q = ((a + 32'h2000_0000) >> 30) & 32'd3;
            r = a - (q << 30);
            z = longint'($signed(r));
            x = TRIG_GAIN;
            y = 0;
            for (int i = 0; i < 30; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_TURN[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_TURN[i];
                end
            end
            case (q)
                32'd0:   begin c = x;  s = y;  end
                32'd1:   begin c = -y; s = x;  end
                32'd2:   begin c = -x; s = -y; end
                default: begin c = y;  s = -x; end
            endcase
        endfunction

        function atb_out_t pack_segment(longint p [8], int total, bit is_last);
            atb_out_t o;
            o.seg_start_x   = clamp32(p[0]);
            o.seg_start_y   = clamp32(p[1]);
            o.seg_end_x     = clamp32(p[2]);
            o.seg_end_y     = clamp32(p[3]);
            o.ctrl_a_x      = clamp32(p[4]);
            o.ctrl_a_y      = clamp32(p[5]);
            o.ctrl_b_x      = clamp32(p[6]);
            o.ctrl_b_y      = clamp32(p[7]);
            o.segment_total = 3'(total);
            o.last          = is_last;
            return o;
        endfunction

        // Works out every segment of one arc and queues them in order.
        function void note_arc(atb_in_t arc);
            longint      cx;
            longint      cy;
            longint      rad;
            longint      bx;
            longint      by;
            longint      p [8];
            longint      c1, s1, c2, s2, tc, ts, t, k;
            longint      x1, y1, x2, y2, kx, ky;
            int          a0;
            int          ang;
            int          diff;
            int          n;
            int          rem;
            int          total;
            logic [31:0] span;
            cx   = longint'(arc.centre_x);
            cy   = longint'(arc.centre_y);
            rad  = longint'(arc.radius);
            bx   = cx * Q30_ONE;
            by   = cy * Q30_ONE;
            a0   = int'(arc.start_angle);
            diff = (int'(arc.stop_angle) - a0) & 16'hFFFF;
            if (diff == 0)
                diff = 65536;
            n     = diff / 16384;
            rem   = diff % 16384;
            total = n + ((rem != 0) ? 1 : 0);
            ang   = a0;
            arcs_noted++;
            // Leading partial segment with its own tangent factor.
            if (rem != 0)
            begin
                ang  = (a0 + rem) & 16'hFFFF;
                span = 32'(rem) << 16;
                sin_cos(32'(a0) << 16, c1, s1);
                sin_cos(32'(ang) << 16, c2, s2);
                sin_cos(span >> 2, tc, ts);
                if (tc <= 0)
                    tc = 1;
                t = (ts * Q30_ONE) / tc;
                k = (t * 4) / 3;
                if (k < 0)
                    k = 0;
                x1 = rad * c1;
                y1 = rad * s1;
                x2 = rad * c2;
                y2 = rad * s2;
                p[0] = cx + trunc_q30(x1);
                p[1] = cy + trunc_q30(y1);
                p[2] = cx + trunc_q30(x2);
                p[3] = cy + trunc_q30(y2);
                p[4] = trunc_q30(bx + x1 - scale_k(k, y1));
                p[5] = trunc_q30(by + y1 + scale_k(k, x1));
                p[6] = trunc_q30(bx + x2 + scale_k(k, y2));
                p[7] = trunc_q30(by + y2 - scale_k(k, x2));
                segments_due.push_back(pack_segment(p, total, total == 1));
            end
            // Whole quarter turns, each from its own start angle.
            for (int idx = (rem != 0) ? 1 : 0; idx < total; idx++)
            begin
                sin_cos(32'(ang) << 16, c1, s1);
                x1 = rad * c1;
                y1 = rad * s1;
                kx = scale_k(K_QTR, x1);
                ky = scale_k(K_QTR, y1);
                p[0] = cx + trunc_q30(x1);
                p[1] = cy + trunc_q30(y1);
                p[2] = cx + trunc_q30(-y1);
                p[3] = cy + trunc_q30(x1);
                p[4] = trunc_q30(bx + x1 - ky);
                p[5] = trunc_q30(by + y1 + kx);
                p[6] = trunc_q30(bx + kx - y1);
                p[7] = trunc_q30(by + ky + x1);
                segments_due.push_back(pack_segment(p, total, idx == total - 1));
                ang = (ang + 16384) & 16'hFFFF;
            end
        endfunction

        // Compares one segment from the block with the oldest expected one.
        function void check_segment(atb_out_t got);
            atb_out_t want;
            segments_seen++;
            if (segments_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: segment with none expected: %p", got);
                return;
            end
            want = segments_due.pop_front();
            if (got.seg_start_x !== want.seg_start_x || got.seg_start_y !== want.seg_start_y
                || got.seg_end_x !== want.seg_end_x || got.seg_end_y !== want.seg_end_y
                || got.ctrl_a_x !== want.ctrl_a_x || got.ctrl_a_y !== want.ctrl_a_y
                || got.ctrl_b_x !== want.ctrl_b_x || got.ctrl_b_y !== want.ctrl_b_y
                || got.segment_total !== want.segment_total || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: segment %0d differs", segments_seen);
                    $display("  expected %p", want);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    atb_in_t  in_item;
    logic     out_valid;
    logic     out_ready;
    atb_out_t out_item;

    segment_scoreboard board;
    bit                steady;
    int                cycles;

    arc_to_bezier_segments_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run length guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("arc_to_bezier_segments_top verification failed");
            $finish;
        end
    end

    // Receiver side: random stalls unless in a steady stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready = 1'b0;
        else
            out_ready = steady ? 1'b1 : ($urandom_range(99) >= 33);
    end

    // Every segment taken by the receiver is checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_segment(out_item);
    end

    // Offers one arc, with random gaps ahead of it, and waits for acceptance.
    task automatic send_arc(input atb_in_t arc);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 33)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = arc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_arc(arc);
    endtask

    task automatic send_fields(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [23:0] rad, input logic [15:0] a0,
                               input logic [15:0] a1);
        atb_in_t arc;
        arc.centre_x    = cx;
        arc.centre_y    = cy;
        arc.radius      = rad;
        arc.start_angle = a0;
        arc.stop_angle  = a1;
        send_arc(arc);
    endtask

    task automatic wait_drained();
        while (board.segments_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        atb_in_t     arc;
        logic [15:0] span;
        board     = new();
        steady    = 1'b0;
        cycles    = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed arcs: full circles, quarter multiples, tiny and
        // near-full spans, wrap through zero and saturating coordinates.
        send_fields(32'd0, 32'd0, 24'd1000, 16'h0000, 16'h0000);
        send_fields(32'd100, -32'sd50, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(32'd0, 32'd0, 24'd0, 16'h1234, 16'h5678);
        send_fields(32'd0, 32'd0, 24'd5000, 16'h0000, 16'h4000);
        send_fields(32'd0, 32'd0, 24'd5000, 16'h2000, 16'hA000);
        send_fields(32'd0, 32'd0, 24'd5000, 16'hC000, 16'h8000);
        send_fields(32'd7, 32'd9, 24'd77777, 16'h0000, 16'h0001);
        send_fields(32'd7, 32'd9, 24'd77777, 16'h0000, 16'h3FFF);
        send_fields(32'd7, 32'd9, 24'd77777, 16'h0001, 16'h0000);
        send_fields(32'd7, 32'd9, 24'd77777, 16'hFFF0, 16'h0010);
        send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 16'h0000, 16'h0000);
        send_fields(32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 16'h0000, 16'h0000);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF, 16'h1111, 16'h9999);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF, 16'h8000, 16'h8001);
        send_fields(32'hFFFF_FFFF, 32'd1, 24'd1, 16'h5555, 16'hAAAA);
        send_fields(-32'sd123456, 32'd654321, 24'h800000, 16'hFFFF, 16'h0000);
        send_fields(32'd0, 32'd0, 24'hFFFFFF, 16'h4000, 16'h7FFF);
        send_fields(32'd0, 32'd0, 24'h000001, 16'hBFFF, 16'hC001);

        // Sender holds off until every directed segment has come back.
        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();

        // Random arcs, mostly ordinary, with a steady stretch in the middle.
        for (int i = 0; i < RANDOM_ARCS; i++)
        begin
            steady = (i >= 150 && i < 230);
            arc.centre_x    = $urandom;
            arc.centre_y    = $urandom;
            arc.radius      = 24'($urandom);
            arc.start_angle = 16'($urandom);
            case ($urandom_range(9))
                0:       span = 16'h0000;
                1:       span = 16'($urandom_range(3)) << 14;
                2:       span = 16'($urandom_range(3)) + 16'($urandom_range(3)) * 16'h4000;
                default: span = 16'($urandom);
            endcase
            arc.stop_angle = arc.start_angle + span;
            if ($urandom_range(3) != 0)
            begin
                // Modest centres and radii keep most coordinates in range.
                arc.centre_x = 32'($signed(20'($urandom)));
                arc.centre_y = 32'($signed(20'($urandom)));
                if ($urandom_range(1) == 0)
                    arc.radius = 24'($urandom_range(65535));
            end
            send_arc(arc);
        end
        steady = 1'b0;
        @(negedge clk);
        in_valid = 1'b0;

        wait_drained();
        repeat (500) @(posedge clk);

        $display("Covered %0d arcs and %0d segments: full circles, quarter multiples,",
                 board.arcs_noted, board.segments_seen);
        $display("partial spans, angle wrap and saturated coordinates; %0d mismatches.",
                 board.mismatches);
        if (board.mismatches == 0 && board.segments_due.size() == 0)
            $display("arc_to_bezier_segments_top verification clean");
        else
            $display("arc_to_bezier_segments_top verification failed");
        $finish;
    end

endmodule

// ===== arc_to_bezier_segments_top.f =====
rtl/core/atb_pkg.sv
rtl/core/atb_cordic.sv
rtl/core/atb_div.sv
rtl/core/atb_front.sv
rtl/core/atb_back.sv
rtl/core/arc_to_bezier_segments_top.sv
bench/arc_to_bezier_segments_top_test.sv
